// ===== hdl/usbtd_pkg.sv =====
// Package for the USB transfer descriptor builder.
// Holds field widths, packet and status codes, and the controller/datapath structs.
package usbtd_pkg;

  localparam int LEN_W    = 11;
  localparam int OFF_W    = 16;
  localparam int LIM_W    = 18;
  localparam int ROW_W    = 32;

  localparam logic [1:0] CMD_BULK  = 2'd0;
  localparam logic [1:0] CMD_CTRL  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] PID_SETUP = 2'd0;
  localparam logic [1:0] PID_IN    = 2'd1;
  localparam logic [1:0] PID_OUT   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MANY  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [LEN_W-1:0] NULL_CODE = 11'd2047;

  localparam logic [2:0] KIND_SETUP     = 3'd0;
  localparam logic [2:0] KIND_DATA      = 3'd1;
  localparam logic [2:0] KIND_STATUS    = 3'd2;
  localparam logic [2:0] KIND_ERR_MANY  = 3'd3;
  localparam logic [2:0] KIND_ERR_EMPTY = 3'd4;

  typedef struct packed {
    logic       load;
    logic       limit;
    logic       emit;
    logic [2:0] kind;
    logic       wb;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_bulk;
    logic empty;
    logic too_many;
    logic data_last;
    logic data_none;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/usb_transfer_descriptor_builder.sv =====
// USB transfer descriptor builder: splits bulk and control requests into packet beats.
// The first result beat is registered after the request is loaded and the controller has
// passed its multiply and evaluate states. Throughput: one result beat per cycle while
// the output is taken; a request holds the block until its last beat (and, for bulk, the
// toggle write-back) is done. A clear request leaves the block idle. Reset clears the
// per-device toggle valid bits at once, so all toggles read as DATA0 with no clearing pass.
module usb_transfer_descriptor_builder #(
  parameter int MAX_PACKET_BYTES        = 1024,
  parameter int MAX_RESULTS             = 64,
  parameter int DEVICE_COUNT            = 128,
  parameter int ENDPOINTS_PER_DIRECTION = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [6:0]  in_device_address,
  input  logic [3:0]  in_endpoint,
  input  logic        in_direction,
  input  logic [15:0] in_data_length,
  input  logic [10:0] in_packet_length,
  input  logic [6:0]  in_setup_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_packet_id,
  output logic [6:0]  out_address,
  output logic [3:0]  out_endpoint,
  output logic        out_data_toggle,
  output logic [10:0] out_length_code,
  output logic        out_buffer_select,
  output logic [15:0] out_buffer_offset,
  output logic [1:0]  out_status_code,
  output logic        out_last
);
  import usbtd_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  usbtd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  usbtd_dp #(
    .MAX_PACKET_BYTES        (MAX_PACKET_BYTES),
    .MAX_RESULTS             (MAX_RESULTS),
    .DEVICE_COUNT            (DEVICE_COUNT),
    .ENDPOINTS_PER_DIRECTION (ENDPOINTS_PER_DIRECTION)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_command        (in_command),
    .in_device_address (in_device_address),
    .in_endpoint       (in_endpoint),
    .in_direction      (in_direction),
    .in_data_length    (in_data_length),
    .in_packet_length  (in_packet_length),
    .in_setup_length   (in_setup_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_packet_id     (out_packet_id),
    .out_address       (out_address),
    .out_endpoint      (out_endpoint),
    .out_data_toggle   (out_data_toggle),
    .out_length_code   (out_length_code),
    .out_buffer_select (out_buffer_select),
    .out_buffer_offset (out_buffer_offset),
    .out_status_code   (out_status_code),
    .out_last          (out_last)
  );

endmodule

// ===== hdl/usbtd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module usbtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/usbtd_ctrl.sv =====
// Controller state machine of the USB transfer descriptor builder.
// Depends on usbtd_pkg for the command and status structs.
module usbtd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_command,
  output logic                in_ready,
  input  usbtd_pkg::dp_stat_t stat,
  output usbtd_pkg::ctl_cmd_t cmd
);
  import usbtd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_BULK  = 4'd3;
  localparam logic [3:0] S_WB    = 4'd4;
  localparam logic [3:0] S_SETUP = 4'd5;
  localparam logic [3:0] S_DATA  = 4'd6;
  localparam logic [3:0] S_STAT  = 4'd7;
  localparam logic [3:0] S_ERRM  = 4'd8;
  localparam logic [3:0] S_ERRE  = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = KIND_DATA;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid && (in_command == CMD_BULK || in_command == CMD_CTRL)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.limit = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (stat.is_bulk && stat.empty) begin
          state_nxt = S_ERRE;
        end else if (stat.too_many) begin
          state_nxt = S_ERRM;
        end else if (stat.is_bulk) begin
          state_nxt = S_BULK;
        end else begin
          state_nxt = S_SETUP;
        end
      end
      S_BULK: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.data_last) begin
            state_nxt = S_WB;
          end
        end
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SETUP: begin
        cmd.kind = KIND_SETUP;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.data_none ? S_STAT : S_DATA;
        end
      end
      S_DATA: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.data_last) begin
            state_nxt = S_STAT;
          end
        end
      end
      S_STAT: begin
        cmd.kind = KIND_STATUS;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ERRM: begin
        cmd.kind = KIND_ERR_MANY;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ERRE: begin
        cmd.kind = KIND_ERR_EMPTY;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/usbtd_dp.sv =====
// Datapath of the USB transfer descriptor builder: request registers, packet
// slicing, toggle store with per-device valid bits, and the result register.
// Depends on usbtd_pkg and usbtd_ram.
module usbtd_dp #(
  parameter int MAX_PACKET_BYTES        = 1024,
  parameter int MAX_RESULTS             = 64,
  parameter int DEVICE_COUNT            = 128,
  parameter int ENDPOINTS_PER_DIRECTION = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  usbtd_pkg::ctl_cmd_t cmd,
  output usbtd_pkg::dp_stat_t stat,
  input  logic [1:0]          in_command,
  input  logic [6:0]          in_device_address,
  input  logic [3:0]          in_endpoint,
  input  logic                in_direction,
  input  logic [15:0]         in_data_length,
  input  logic [10:0]         in_packet_length,
  input  logic [6:0]          in_setup_length,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_packet_id,
  output logic [6:0]          out_address,
  output logic [3:0]          out_endpoint,
  output logic                out_data_toggle,
  output logic [10:0]         out_length_code,
  output logic                out_buffer_select,
  output logic [15:0]         out_buffer_offset,
  output logic [1:0]          out_status_code,
  output logic                out_last
);
  import usbtd_pkg::*;

  localparam int AW = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam logic [7:0]       DEV_LIM  = 8'(DEVICE_COUNT);
  localparam logic [4:0]       EP_LIM   = 5'(ENDPOINTS_PER_DIRECTION);
  localparam logic [LEN_W-1:0] MAX_PKT  = LEN_W'(MAX_PACKET_BYTES);
  localparam logic [LIM_W-1:0] RES_L    = LIM_W'(MAX_RESULTS);
  localparam logic [LIM_W-1:0] CTRL_LIM = LIM_W'((MAX_RESULTS - 2) * MAX_PACKET_BYTES);

  logic             bulk_r;
  logic [6:0]       addr_r;
  logic [3:0]       ep_r;
  logic             dir_r;
  logic [15:0]      left_r;
  logic [15:0]      off_r;
  logic [LEN_W-1:0] plen_r;
  logic [6:0]       slen_r;
  logic             mapped_r;
  logic             vld_hit_r;
  logic [ROW_W-1:0] row_r;
  logic             tog_r;
  logic [LIM_W-1:0] limit_r;
  logic [DEVICE_COUNT-1:0] row_vld_r;

  logic [LEN_W-1:0] plen_in;
  logic             in_mapped;
  logic [AW-1:0]    in_row;
  logic [AW-1:0]    row_idx;
  logic [4:0]       slot;
  logic [ROW_W-1:0] rdata;
  logic [ROW_W-1:0] row_eff;
  logic [ROW_W-1:0] wb_row;
  logic             ram_we;
  logic             data_last;
  logic [LEN_W-1:0] chunk;

  logic             out_valid_r;
  logic [1:0]       pid_r;
  logic [6:0]       oaddr_r;
  logic [3:0]       oep_r;
  logic             otog_r;
  logic [LEN_W-1:0] olen_r;
  logic             obsel_r;
  logic [15:0]      ooff_r;
  logic [1:0]       ostat_r;
  logic             olast_r;

  assign in_row  = in_device_address[AW-1:0];
  assign row_idx = addr_r[AW-1:0];
  assign slot    = {dir_r, ep_r};

  always_comb begin
    if (in_command == CMD_CTRL) begin
      plen_in = MAX_PKT;
    end else if (in_packet_length == '0) begin
      plen_in = LEN_W'(1);
    end else if (in_packet_length > MAX_PKT) begin
      plen_in = MAX_PKT;
    end else begin
      plen_in = in_packet_length;
    end
  end

  assign in_mapped = ({1'b0, in_device_address} < DEV_LIM) && ({1'b0, in_endpoint} < EP_LIM);

  assign data_last = (left_r <= 16'(plen_r));
  assign chunk     = data_last ? left_r[LEN_W-1:0] : plen_r;
  assign row_eff   = vld_hit_r ? rdata : '0;

  always_comb begin
    wb_row       = row_r;
    wb_row[slot] = tog_r;
  end

  assign ram_we = cmd.wb && mapped_r;

  usbtd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEVICE_COUNT)
  ) u_toggle_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_idx),
    .wdata (wb_row),
    .raddr (in_row),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (cmd.load && in_command == CMD_CLEAR && ({1'b0, in_device_address} < DEV_LIM)) begin
      row_vld_r[in_row] <= 1'b0;
    end else if (ram_we) begin
      row_vld_r[row_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bulk_r    <= (in_command == CMD_BULK);
      addr_r    <= in_device_address;
      ep_r      <= (in_command == CMD_BULK) ? in_endpoint : 4'd0;
      dir_r     <= in_direction;
      left_r    <= in_data_length;
      off_r     <= '0;
      plen_r    <= plen_in;
      slen_r    <= in_setup_length;
      mapped_r  <= in_mapped && (in_command == CMD_BULK);
      vld_hit_r <= ({1'b0, in_device_address} < DEV_LIM) ? row_vld_r[in_row] : 1'b0;
    end
    if (cmd.limit) begin
      limit_r <= bulk_r ? LIM_W'(plen_r) * RES_L : CTRL_LIM;
      row_r   <= row_eff;
      tog_r   <= bulk_r ? (mapped_r & row_eff[slot]) : 1'b1;
    end
    if (cmd.emit && cmd.kind == KIND_DATA) begin
      left_r <= left_r - 16'(chunk);
      off_r  <= off_r + 16'(chunk);
      tog_r  <= bulk_r ? (tog_r ^ mapped_r) : ~tog_r;
    end
  end

  assign stat.is_bulk   = bulk_r;
  assign stat.empty     = (left_r == '0);
  assign stat.too_many  = (LIM_W'(left_r) > limit_r);
  assign stat.data_last = data_last;
  assign stat.data_none = (left_r == '0);
  assign stat.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.kind)
        KIND_SETUP: begin
          pid_r   <= PID_SETUP;
          oaddr_r <= addr_r;
          oep_r   <= ep_r;
          otog_r  <= 1'b0;
          olen_r  <= (slen_r == '0) ? NULL_CODE : LEN_W'(slen_r - 7'd1);
          obsel_r <= 1'b1;
          ooff_r  <= '0;
          ostat_r <= ST_OK;
          olast_r <= 1'b0;
        end
        KIND_STATUS: begin
          pid_r   <= dir_r ? PID_OUT : PID_IN;
          oaddr_r <= addr_r;
          oep_r   <= ep_r;
          otog_r  <= 1'b1;
          olen_r  <= NULL_CODE;
          obsel_r <= 1'b0;
          ooff_r  <= '0;
          ostat_r <= ST_OK;
          olast_r <= 1'b1;
        end
        KIND_ERR_MANY, KIND_ERR_EMPTY: begin
          pid_r   <= PID_SETUP;
          oaddr_r <= '0;
          oep_r   <= '0;
          otog_r  <= 1'b0;
          olen_r  <= '0;
          obsel_r <= 1'b0;
          ooff_r  <= '0;
          ostat_r <= (cmd.kind == KIND_ERR_MANY) ? ST_MANY : ST_EMPTY;
          olast_r <= 1'b1;
        end
        default: begin
          pid_r   <= dir_r ? PID_IN : PID_OUT;
          oaddr_r <= addr_r;
          oep_r   <= ep_r;
          otog_r  <= tog_r;
          olen_r  <= chunk - LEN_W'(1);
          obsel_r <= 1'b0;
          ooff_r  <= off_r;
          ostat_r <= ST_OK;
          olast_r <= bulk_r && data_last;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packet_id     = pid_r;
  assign out_address       = oaddr_r;
  assign out_endpoint      = oep_r;
  assign out_data_toggle   = otog_r;
  assign out_length_code   = olen_r;
  assign out_buffer_select = obsel_r;
  assign out_buffer_offset = ooff_r;
  assign out_status_code   = ostat_r;
  assign out_last          = olast_r;

endmodule
